// ----- hw/rtl/sfd_pkg.sv -----
// Shared types and constants for the frame decoder.
package sfd_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int ADDR_W      = 5;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_PLAIN  = 8'h00;
    localparam logic [7:0] END_VOLT   = 8'h04;
    localparam logic [7:0] END_GPS    = 8'h14;
    localparam logic [7:0] END_ALT_A  = 8'h24;
    localparam logic [7:0] END_ALT_B  = 8'h34;
    localparam logic [7:0] TAG_VOLT   = 8'h03;
    localparam logic [7:0] TAG_GPS    = 8'h13;

    localparam logic [ADDR_W-1:0] FLAGS_POS = 5'd23;
    localparam logic [ADDR_W-1:0] END_POS   = 5'd24;
    localparam logic [ADDR_W-1:0] VOLT_SIZE = 5'd3;
    localparam logic [ADDR_W-1:0] GPS_SIZE  = 5'd24;
    localparam logic [ADDR_W-1:0] FULL_FILL = 5'd25;
    localparam logic [4:0] PROP_CHANNELS    = 5'd16;
    localparam logic [4:0] MAX_CH_RESET     = 5'd18;

    localparam logic [11:0] SCALE_OFFSET = 12'd874;
    localparam logic [11:0] SWITCH_LOW   = 12'd998;
    localparam logic [11:0] SWITCH_HIGH  = 12'd1998;

    typedef enum logic [1:0] {
        MODE_DESYNC  = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_VOLT    = 2'd2,
        MODE_GPS     = 2'd3
    } mode_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// ----- hw/rtl/sfd_store.sv -----
// Frame byte store: one write port, one read port with registered data.
module sfd_store
(
    input  logic              clk,
    input  sfd_pkg::mem_req_t req,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [0:sfd_pkg::FRAME_BYTES-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/sfd_ctrl.sv -----
// Parser sequencer: byte intake, frame decode, resync search and store shift.
module sfd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,
    output logic              m_axis_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data,
    output sfd_pkg::mem_req_t req,
    input  logic [7:0]        rd_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FL_RD, ST_FL_CAP, ST_CH0, ST_CH1, ST_CH2, ST_CH3,
        ST_OUT, ST_SRCH, ST_COPY
    } state_t;

    state_t         state_reg, state_next;
    sfd_pkg::mode_t mode_reg, mode_next;
    logic [4:0]     fill_reg, fill_next;
    logic [31:0]    drop_reg, drop_next;
    logic [4:0]     maxch_reg;
    logic [7:0]     b0_reg, b0_next;
    logic [7:0]     flags_reg, flags_next;
    logic [7:0]     bp_reg, bp_next;
    logic [4:0]     k_reg, k_next;
    logic [15:0]    w_reg, w_next;
    logic [4:0]     idx_reg, idx_next;
    logic [4:0]     dst_reg, dst_next;
    logic [4:0]     start_reg, start_next;
    logic           pend_reg, pend_next;
    logic           ov_reg, ov_next;
    logic [4:0]     oidx_reg, oidx_next;
    logic [11:0]    oval_reg, oval_next;
    logic           olast_reg, olast_next;

    logic [4:0]     n_ch;
    logic           sw_en;
    logic [4:0]     total;
    logic [4:0]     base;
    logic [23:0]    word;
    logic [10:0]    raw;
    logic [13:0]    scaled;
    logic [7:0]     first;
    logic [4:0]     fill_eff;
    sfd_pkg::mode_t mode_eff;
    logic [4:0]     size;
    logic [7:0]     tag;

    assign n_ch   = (maxch_reg > sfd_pkg::PROP_CHANNELS) ? sfd_pkg::PROP_CHANNELS : maxch_reg;
    assign sw_en  = (maxch_reg > 5'd17);
    assign total  = sw_en ? 5'd18 : n_ch;
    assign base   = 5'd1 + bp_reg[7:3];
    assign word   = {rd_data, w_reg};
    assign raw    = 11'(word >> bp_reg[2:0]);
    assign scaled = ({3'b0, raw} << 2) + {3'b0, raw} + 14'd4;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {5'b0, drop_reg, flags_reg[3] | flags_reg[2], flags_reg[3],
                            oval_reg, oidx_reg};

    assign fill_eff = (fill_reg >= sfd_pkg::FULL_FILL) ? 5'd0 : fill_reg;
    assign mode_eff = (fill_reg >= sfd_pkg::FULL_FILL) ? sfd_pkg::MODE_DESYNC : mode_reg;
    assign first    = (fill_eff == 5'd0) ? s_axis_tdata : b0_reg;
    assign size     = (mode_eff == sfd_pkg::MODE_VOLT) ? sfd_pkg::VOLT_SIZE : sfd_pkg::GPS_SIZE;
    assign tag      = (mode_eff == sfd_pkg::MODE_VOLT) ? sfd_pkg::TAG_VOLT : sfd_pkg::TAG_GPS;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        fill_next  = fill_reg;
        drop_next  = drop_reg;
        b0_next    = b0_reg;
        flags_next = flags_reg;
        bp_next    = bp_reg;
        k_next     = k_reg;
        w_next     = w_reg;
        idx_next   = idx_reg;
        dst_next   = dst_reg;
        start_next = start_reg;
        pend_next  = pend_reg;
        ov_next    = ov_reg;
        oidx_next  = oidx_reg;
        oval_next  = oval_reg;
        olast_next = olast_reg;
        req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    fill_next = fill_eff;
                    mode_next = mode_eff;
                    case (mode_eff)
                        sfd_pkg::MODE_DESYNC:
                        begin
                            if (s_axis_tdata == sfd_pkg::START_BYTE)
                            begin
                                req.we    = 1'b1;
                                req.waddr = '0;
                                req.wdata = s_axis_tdata;
                                b0_next   = s_axis_tdata;
                                fill_next = 5'd1;
                                mode_next = sfd_pkg::MODE_COLLECT;
                            end
                        end
                        sfd_pkg::MODE_COLLECT:
                        begin
                            req.we    = 1'b1;
                            req.waddr = fill_eff;
                            req.wdata = s_axis_tdata;
                            fill_next = fill_eff + 5'd1;
                            if (fill_eff == 5'd0)
                            begin
                                b0_next = s_axis_tdata;
                            end
                            if (fill_eff == sfd_pkg::END_POS)
                            begin
                                if (b0_reg != sfd_pkg::START_BYTE)
                                begin
                                    drop_next  = drop_reg + 32'd1;
                                    state_next = ST_SRCH;
                                end
                                else if (s_axis_tdata == sfd_pkg::END_PLAIN ||
                                         s_axis_tdata == sfd_pkg::END_ALT_A ||
                                         s_axis_tdata == sfd_pkg::END_ALT_B)
                                begin
                                    mode_next  = sfd_pkg::MODE_COLLECT;
                                    fill_next  = '0;
                                    state_next = ST_FL_RD;
                                end
                                else if (s_axis_tdata == sfd_pkg::END_VOLT)
                                begin
                                    mode_next  = sfd_pkg::MODE_VOLT;
                                    fill_next  = '0;
                                    state_next = ST_FL_RD;
                                end
                                else if (s_axis_tdata == sfd_pkg::END_GPS)
                                begin
                                    mode_next  = sfd_pkg::MODE_GPS;
                                    fill_next  = '0;
                                    state_next = ST_FL_RD;
                                end
                                else
                                begin
                                    state_next = ST_SRCH;
                                end
                                idx_next  = 5'd1;
                                pend_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            req.we    = 1'b1;
                            req.waddr = fill_eff;
                            req.wdata = s_axis_tdata;
                            fill_next = fill_eff + 5'd1;
                            if (fill_eff == 5'd0)
                            begin
                                b0_next = s_axis_tdata;
                                if (s_axis_tdata == sfd_pkg::START_BYTE)
                                begin
                                    mode_next = sfd_pkg::MODE_COLLECT;
                                end
                            end
                            if (fill_eff + 5'd1 >= size)
                            begin
                                if (first == tag)
                                begin
                                    fill_next = '0;
                                end
                                else
                                begin
                                    mode_next = sfd_pkg::MODE_DESYNC;
                                    drop_next = drop_reg + 32'd1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_FL_RD:
            begin
                req.raddr  = sfd_pkg::FLAGS_POS;
                state_next = ST_FL_CAP;
            end
            ST_FL_CAP:
            begin
                flags_next = rd_data;
                k_next     = '0;
                bp_next    = '0;
                state_next = (n_ch == 5'd0) ? ST_IDLE : ST_CH0;
            end
            ST_CH0:
            begin
                req.raddr  = base;
                state_next = ST_CH1;
            end
            ST_CH1:
            begin
                req.raddr   = base + 5'd1;
                w_next[7:0] = rd_data;
                state_next  = ST_CH2;
            end
            ST_CH2:
            begin
                req.raddr    = base + 5'd2;
                w_next[15:8] = rd_data;
                state_next   = ST_CH3;
            end
            ST_CH3:
            begin
                oidx_next  = k_reg;
                oval_next  = 12'(scaled >> 3) + sfd_pkg::SCALE_OFFSET;
                olast_next = (k_reg + 5'd1 == total);
                ov_next    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    ov_next = 1'b0;
                    k_next  = k_reg + 5'd1;
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (k_reg + 5'd1 < n_ch)
                    begin
                        bp_next    = bp_reg + 8'd11;
                        state_next = ST_CH0;
                    end
                    else
                    begin
                        oidx_next  = k_reg + 5'd1;
                        oval_next  = (k_reg[0] ? flags_reg[0] : flags_reg[1]) ?
                                     sfd_pkg::SWITCH_HIGH : sfd_pkg::SWITCH_LOW;
                        olast_next = (k_reg + 5'd2 == total);
                        ov_next    = 1'b1;
                    end
                end
            end
            ST_SRCH:
            begin
                if (pend_reg && rd_data == sfd_pkg::START_BYTE)
                begin
                    start_next = idx_reg - 5'd1;
                    idx_next   = idx_reg - 5'd1;
                    dst_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_COPY;
                end
                else if (pend_reg && idx_reg == sfd_pkg::FULL_FILL)
                begin
                    fill_next  = '0;
                    mode_next  = sfd_pkg::MODE_DESYNC;
                    state_next = ST_IDLE;
                end
                else
                begin
                    req.raddr = idx_reg;
                    idx_next  = idx_reg + 5'd1;
                    pend_next = 1'b1;
                end
            end
            ST_COPY:
            begin
                if (pend_reg)
                begin
                    req.we    = 1'b1;
                    req.waddr = dst_reg;
                    req.wdata = rd_data;
                    dst_next  = dst_reg + 5'd1;
                end
                if (idx_reg < sfd_pkg::FULL_FILL)
                begin
                    req.raddr = idx_reg;
                    idx_next  = idx_reg + 5'd1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        fill_next  = sfd_pkg::FULL_FILL - start_reg;
                        mode_next  = sfd_pkg::MODE_COLLECT;
                        b0_next    = sfd_pkg::START_BYTE;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= sfd_pkg::MODE_DESYNC;
            fill_reg  <= '0;
            drop_reg  <= '0;
            maxch_reg <= sfd_pkg::MAX_CH_RESET;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
            if (cfg_valid)
            begin
                maxch_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg    <= b0_next;
        flags_reg <= flags_next;
        bp_reg    <= bp_next;
        k_reg     <= k_next;
        w_reg     <= w_next;
        idx_reg   <= idx_next;
        dst_reg   <= dst_next;
        start_reg <= start_next;
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= sfd_pkg::FULL_FILL)
        else $error("fill count out of range");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> req.waddr < sfd_pkg::FULL_FILL)
        else $error("store write beyond frame");

    a_no_intake_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> !s_axis_tready)
        else $error("byte taken while word pending");

    a_more_after_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && m_axis_tready && !olast_reg) |=> !s_axis_tready)
        else $error("frame emission stopped early");

endmodule

// ----- hw/rtl/sbus_frame_decoder_top.sv -----
// Timing: a byte is taken only while idle; at a frame end the input is held while the flags are read,
// while each proportional channel is read from the store and scaled (states CH0 to CH3) and handed over,
// and while each switch channel is handed over, for up to 18 channels.
// A rejected frame has its store scanned for a later start byte; a shift to that start byte scans and
// then copies the bytes down, limited by the single read port of the frame store.
// Reset: asynchronous, active low; clears mode, fill, drops, output valid; channel limit 18.
module sbus_frame_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // channel_index, channel_value, failsafe, frame_lost, drop_total
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data        // chan_limit
);

    sfd_pkg::mem_req_t req;
    logic [7:0]        rd_data;

    sfd_store u_store
    (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    sfd_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .req           (req),
        .rd_data       (rd_data)
    );

endmodule
